// File: rtl/pbd_pkg.sv
// Shared widths, reset values and types of the pseudospin derivative block.
`default_nettype none
package pbd_pkg;

    localparam int NUM_SPINS_DEF = 64;
    localparam int SPIN_W        = 16;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int VAL_W         = 32;
    localparam int PROD_W        = VAL_W + SPIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_COUPLING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP = 2'd2;

    localparam logic [CFG_W-1:0] COUPLING_RST   = 24'd65536;
    localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 24'd65536;
    localparam logic [CFG_W-1:0] LEVEL_STEP_RST = 24'd2080;

    typedef struct packed {
        logic signed [SPIN_W-1:0] x;
        logic signed [SPIN_W-1:0] y;
        logic signed [SPIN_W-1:0] z;
    } t_spin;

    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic signed [VAL_W-1:0] eps;
    } t_issue;

endpackage
`default_nettype wire

// File: rtl/pbd_store.sv
// Spin store: one write port, one registered read port.
`default_nettype none
module pbd_store
    import pbd_pkg::*;
#(
    parameter int NUM_SPINS = NUM_SPINS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [$clog2(NUM_SPINS)-1:0]  i_waddr,
    input  t_spin                        i_wdata,
    input  wire                          i_re,
    input  wire [$clog2(NUM_SPINS)-1:0]  i_raddr,
    output t_spin                        o_rdata
);

    t_spin r_mem [NUM_SPINS];
    t_spin r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/pbd_deriv.sv
// Derivative datapath: product stage, then rounding, saturation and output register.
`default_nettype none
module pbd_deriv
    import pbd_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_adv,
    input  t_issue                  i_issue,
    input  t_spin                   i_spin,
    input  wire signed [VAL_W-1:0]  i_gap,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic                    o_last,
    output logic signed [VAL_W-1:0] o_dx,
    output logic signed [VAL_W-1:0] o_dy,
    output logic signed [VAL_W-1:0] o_dz
);

    logic                     r_valid2;
    logic                     r_last2;
    logic signed [PROD_W-1:0] r_ey;
    logic signed [PROD_W-1:0] r_ex;
    logic signed [PROD_W-1:0] r_gz;
    logic signed [PROD_W-1:0] r_gy;
    logic                     r_valid;
    logic                     r_last;
    logic signed [VAL_W-1:0]  r_dx;
    logic signed [VAL_W-1:0]  r_dy;
    logic signed [VAL_W-1:0]  r_dz;
    logic signed [PROD_W:0]   w_px;
    logic signed [PROD_W:0]   w_py;
    logic signed [PROD_W:0]   w_pz;

    // Twice the product over 2^15 is the product over 2^14, floored.
    function automatic logic signed [VAL_W-1:0] sat_q14(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] t;
        t = v >>> 14;
        if (t > $signed((PROD_W+1)'(32'h7FFFFFFF))) begin
            sat_q14 = 32'sh7FFFFFFF;
        end else if (t < -$signed((PROD_W+1)'(33'h080000000))) begin
            sat_q14 = 32'sh80000000;
        end else begin
            sat_q14 = t[VAL_W-1:0];
        end
    endfunction

    assign w_px = $signed((PROD_W+1)'(0)) - $signed({r_ey[PROD_W-1], r_ey});
    assign w_py = $signed({r_ex[PROD_W-1], r_ex}) + $signed({r_gz[PROD_W-1], r_gz});
    assign w_pz = $signed((PROD_W+1)'(0)) - $signed({r_gy[PROD_W-1], r_gy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_adv) begin
            r_valid2 <= i_issue.valid;
            r_valid  <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_last2 <= i_issue.last;
            r_ey    <= i_issue.eps * i_spin.y;
            r_ex    <= i_issue.eps * i_spin.x;
            r_gz    <= i_gap * i_spin.z;
            r_gy    <= i_gap * i_spin.y;
            r_last  <= r_last2;
            r_dx    <= sat_q14(w_px);
            r_dy    <= sat_q14(w_py);
            r_dz    <= sat_q14(w_pz);
        end
    end

    assign o_busy  = r_valid2;
    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_dz    = r_dz;

endmodule
`default_nettype wire

// File: rtl/pseudospin_bcs_derivative.sv
// Top level of the pseudospin derivative block: load control, gap, emission sequencer.
// Spins are loaded at one beat per cycle into a single-port-write, registered-read store
// while their x components are summed. The beat marked last starts gap computation in
// the GPROD and GSHIFT states, after which one derivative beat per stored spin leaves the
// store read pipeline at up to one per cycle while the output is not stalled; the input
// is stalled from the last beat until the emission pipeline has drained.
`default_nettype none
module pseudospin_bcs_derivative
    import pbd_pkg::*;
#(
    parameter int NUM_SPINS = NUM_SPINS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire signed [SPIN_W-1:0] i_spin_x,
    input  wire signed [SPIN_W-1:0] i_spin_y,
    input  wire signed [SPIN_W-1:0] i_spin_z,
    input  wire                     i_last_spin,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic signed [VAL_W-1:0] o_deriv_x,
    output logic signed [VAL_W-1:0] o_deriv_y,
    output logic signed [VAL_W-1:0] o_deriv_z,
    output logic                    o_last_out,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [CFG_W-1:0]         i_cfg_data
);

    localparam int AW  = $clog2(NUM_SPINS);
    localparam int CW  = $clog2(NUM_SPINS + 1);
    localparam int SW  = SPIN_W + AW;
    localparam int GPW = SW + CFG_W + 1;

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_GPROD  = 2'd1;
    localparam logic [1:0] ST_GSHIFT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]              r_state;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_idx;
    logic signed [SW-1:0]    r_sum;
    logic signed [GPW-1:0]   r_gprod;
    logic signed [VAL_W-1:0] r_gap;
    logic signed [VAL_W-1:0] r_eps;
    logic [CFG_W-1:0]        r_coupling;
    logic [CFG_W-1:0]        r_half_width;
    logic [CFG_W-1:0]        r_level_step;
    t_issue                  r_s1;

    logic  w_in_fire;
    logic  w_store;
    logic  w_adv;
    logic  w_issue;
    logic  w_busy;
    t_spin w_wdata;
    t_spin w_rdata;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_store     = w_in_fire && (r_count < CW'(NUM_SPINS));
    assign w_adv       = !o_out_valid || !i_out_stall;
    assign w_issue     = (r_state == ST_EMIT) && w_adv && (r_idx < r_count);
    assign w_wdata     = '{x: i_spin_x, y: i_spin_y, z: i_spin_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling   <= COUPLING_RST;
            r_half_width <= HALF_WIDTH_RST;
            r_level_step <= LEVEL_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COUPLING:   r_coupling   <= i_cfg_data;
                REG_HALF_WIDTH: r_half_width <= i_cfg_data;
                REG_LEVEL_STEP: r_level_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_store) begin
                        r_count <= r_count + CW'(1);
                        r_sum   <= r_sum + SW'(i_spin_x);
                    end
                    if (w_in_fire && i_last_spin) begin
                        r_state <= ST_GPROD;
                    end
                end
                ST_GPROD: begin
                    r_state <= ST_GSHIFT;
                end
                ST_GSHIFT: begin
                    r_idx   <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if ((r_idx == r_count) && !r_s1.valid && !w_busy) begin
                        r_count <= '0;
                        r_sum   <= '0;
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_GPROD) begin
            r_gprod <= $signed({1'b0, r_coupling}) * r_sum;
        end
        if (r_state == ST_GSHIFT) begin
            r_gap <= VAL_W'(r_gprod >>> 15);
            r_eps <= $signed(VAL_W'(0)) - $signed(VAL_W'(r_half_width));
        end else if (w_issue) begin
            r_eps <= r_eps + $signed(VAL_W'(r_level_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_adv) begin
            r_s1.valid <= w_issue;
        end
        if (w_adv) begin
            r_s1.last <= (r_idx + CW'(1) == r_count);
            r_s1.eps  <= r_eps;
        end
    end

    pbd_store #(
        .NUM_SPINS (NUM_SPINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_adv),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    pbd_deriv u_deriv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_issue (r_s1),
        .i_spin  (w_rdata),
        .i_gap   (r_gap),
        .o_busy  (w_busy),
        .o_valid (o_out_valid),
        .o_last  (o_last_out),
        .o_dx    (o_deriv_x),
        .o_dy    (o_deriv_y),
        .o_dz    (o_deriv_z)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_SPINS))
        else $error("spin count exceeds the store depth");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GSHIFT) |-> (r_count != '0))
        else $error("emission started with an empty store");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |-> (!r_s1.valid && !w_busy))
        else $error("input beat accepted while emission pipeline holds data");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> (r_idx <= r_count))
        else $error("read index ran past the stored spins");

endmodule
`default_nettype wire

// File: sim/pseudospin_bcs_derivative_test.sv
// Self-checking testbench for the pseudospin derivative block with a fixed-point predictor.
module pseudospin_bcs_derivative_test;
    import pbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SPINS = NUM_SPINS_DEF;
    localparam int RANDOM_ITEMS = 230;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct {
        logic signed [VAL_W-1:0] dx;
        logic signed [VAL_W-1:0] dy;
        logic signed [VAL_W-1:0] dz;
        logic                    last;
    } t_deriv_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [SPIN_W-1:0] i_spin_x = '0;
    logic signed [SPIN_W-1:0] i_spin_y = '0;
    logic signed [SPIN_W-1:0] i_spin_z = '0;
    logic i_last_spin = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_deriv_x;
    logic signed [VAL_W-1:0] o_deriv_y;
    logic signed [VAL_W-1:0] o_deriv_z;
    logic o_last_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [CFG_W-1:0] cur_coupling = COUPLING_RST;
    logic [CFG_W-1:0] cur_half_width = HALF_WIDTH_RST;
    logic [CFG_W-1:0] cur_level_step = LEVEL_STEP_RST;
    logic signed [SPIN_W-1:0] held_x [NUM_SPINS];
    logic signed [SPIN_W-1:0] held_y [NUM_SPINS];
    logic signed [SPIN_W-1:0] held_z [NUM_SPINS];
    int held_count = 0;
    int sum_x = 0;

    t_deriv_beat pending_derivs [$];
    t_deriv_beat exp_beat;
    int fail_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b0;
    bit stall_active = 1'b0;
    int stall_left = 0;
    int stall_pick;

    pseudospin_bcs_derivative #(
        .NUM_SPINS(NUM_SPINS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_spin_x(i_spin_x),
        .i_spin_y(i_spin_y),
        .i_spin_z(i_spin_z),
        .i_last_spin(i_last_spin),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_deriv_x(o_deriv_x),
        .o_deriv_y(o_deriv_y),
        .o_deriv_z(o_deriv_z),
        .o_last_out(o_last_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!stall_active) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 70) begin
                i_out_stall = 1'b0;
            end else if (stall_pick < 95) begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_derivs.size() == 0) begin
                $error("derivative beat with no expectation waiting");
                fail_count++;
            end else begin
                exp_beat = pending_derivs.pop_front();
                if (o_deriv_x !== exp_beat.dx) begin
                    $error("deriv_x: expected %0d, actual %0d", exp_beat.dx, o_deriv_x);
                    fail_count++;
                end
                if (o_deriv_y !== exp_beat.dy) begin
                    $error("deriv_y: expected %0d, actual %0d", exp_beat.dy, o_deriv_y);
                    fail_count++;
                end
                if (o_deriv_z !== exp_beat.dz) begin
                    $error("deriv_z: expected %0d, actual %0d", exp_beat.dz, o_deriv_z);
                    fail_count++;
                end
                if (o_last_out !== exp_beat.last) begin
                    $error("last_out: expected %0d, actual %0d", exp_beat.last, o_last_out);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] clamp32(input longint v);
        if (v > SAT_HI) return SAT_HI[VAL_W-1:0];
        if (v < SAT_LO) return SAT_LO[VAL_W-1:0];
        return v[VAL_W-1:0];
    endfunction

    task automatic absorb_spin(input logic signed [SPIN_W-1:0] sx, sy, sz, input logic lst);
        longint cpl, hw, ls, gap, eps, x, y, z;
        t_deriv_beat beat;
        if (held_count < NUM_SPINS) begin
            held_x[held_count] = sx;
            held_y[held_count] = sy;
            held_z[held_count] = sz;
            sum_x += sx;
            held_count++;
        end
        if (lst) begin
            cpl = cur_coupling;
            hw = cur_half_width;
            ls = cur_level_step;
            gap = (cpl * longint'(sum_x)) >>> 15;
            for (int i = 0; i < held_count; i++) begin
                eps = longint'(i) * ls - hw;
                x = held_x[i];
                y = held_y[i];
                z = held_z[i];
                beat.dx = clamp32((-2 * eps * y) >>> 15);
                beat.dy = clamp32((2 * eps * x + 2 * gap * z) >>> 15);
                beat.dz = clamp32((-2 * gap * y) >>> 15);
                beat.last = (i + 1 == held_count);
                pending_derivs.push_back(beat);
            end
            held_count = 0;
            sum_x = 0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SPIN_W-1:0] rand_spin();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (r == 2) return 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] rand_cfg(input logic [CFG_W-1:0] rst_val);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return rst_val;
        if (r == 3) return CFG_W'($urandom_range(0, 4096));
        return CFG_W'($urandom);
    endfunction

    task automatic send_spin(input logic [SPIN_W-1:0] sx, sy, sz, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_spin_x = sx;
        i_spin_y = sy;
        i_spin_z = sz;
        i_last_spin = lst;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        absorb_spin(sx, sy, sz, lst);
        @(negedge i_clk);
    endtask

    task automatic send_random_set(input int len);
        for (int k = 0; k < len; k++) begin
            send_spin(rand_spin(), rand_spin(), rand_spin(), k == len - 1);
        end
    endtask

    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (pending_derivs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_in_valid = 1'b0;
        i_cfg_index = idx;
        i_cfg_data = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_COUPLING:   cur_coupling = val;
            REG_HALF_WIDTH: cur_half_width = val;
            REG_LEVEL_STEP: cur_level_step = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_config();
        gaps_on = 1'b0;
        stall_active = 1'b0;
        send_spin(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
        send_spin(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        send_spin(16'h0001, 16'hFFFF, 16'h7FFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_lone_spin();
        gaps_on = 1'b1;
        stall_active = 1'b1;
        send_spin(16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_spin(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_spin(16'h0000, 16'h0000, 16'h0000, 1'b1);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_COUPLING, '0);
        write_reg(REG_HALF_WIDTH, '1);
        write_reg(REG_LEVEL_STEP, '1);
        send_random_set(4);
        wait_drain();
        write_reg(REG_COUPLING, '1);
        write_reg(REG_HALF_WIDTH, '0);
        write_reg(REG_LEVEL_STEP, '0);
        send_random_set(4);
        wait_drain();
        write_reg(REG_UNUSED, '1);
        send_random_set(2);
        wait_drain();
    endtask

    task automatic test_full_store();
        write_reg(REG_COUPLING, '1);
        write_reg(REG_HALF_WIDTH, '0);
        write_reg(REG_LEVEL_STEP, '1);
        for (int k = 0; k < NUM_SPINS; k++) begin
            send_spin(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        end
        // Beats beyond a full store must be neither stored nor summed.
        repeat (3) send_spin(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        send_spin(16'h8000, 16'h8000, 16'h8000, 1'b1);
        wait_drain();
        write_reg(REG_HALF_WIDTH, '1);
        write_reg(REG_LEVEL_STEP, '0);
        for (int k = 0; k < NUM_SPINS; k++) begin
            send_spin(16'h7FFF, 16'h7FFF, 16'h8000, k == NUM_SPINS - 1);
        end
        wait_drain();
    endtask

    task automatic test_random_sets();
        int sent;
        int sets;
        int len;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drain();
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_active = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) write_reg(REG_COUPLING, rand_cfg(COUPLING_RST));
            if ($urandom_range(0, 1)) write_reg(REG_HALF_WIDTH, rand_cfg(HALF_WIDTH_RST));
            if ($urandom_range(0, 1)) write_reg(REG_LEVEL_STEP, rand_cfg(LEVEL_STEP_RST));
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
            sets = $urandom_range(1, 6);
            for (int s = 0; s < sets && sent < RANDOM_ITEMS; s++) begin
                r = $urandom_range(0, 99);
                if (r < 75) len = $urandom_range(1, 8);
                else if (r < 95) len = $urandom_range(9, 64);
                else len = $urandom_range(65, 70);
                send_random_set(len);
                sent += len;
                if ($urandom_range(0, 4) == 0) wait_drain();
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_reset_config();
        test_lone_spin();
        test_register_extremes();
        test_full_store();
        test_random_sets();
        wait_drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
